// ----- hw/rtl/murmur2_hash_engine_core_macros.svh -----
// assertion helpers, clocked on clk and held off during rst
`ifndef MURMUR2_HASH_ENGINE_CORE_MACROS_SVH
`define MURMUR2_HASH_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define MM2_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MM2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mm2hash_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mm2hash_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned VB_W   = 3;
  localparam int unsigned ADDR_W = 3;

  localparam logic [DATA_W-1:0] MUL_CONST = 32'h5bd1e995;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_SEED = 1'b0;

  // datapath operations, one multiply each
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_KEY1 = 3'd1;  // k = word * m
  localparam logic [2:0] OP_KEY2 = 3'd2;  // k = (k ^ k >> 24) * m
  localparam logic [2:0] OP_HASH = 3'd3;  // h = h * m ^ k
  localparam logic [2:0] OP_TAIL = 3'd4;  // h = (h ^ tail bytes) * m
  localparam logic [2:0] OP_FIN  = 3'd5;  // h = (h ^ h >> 13) * m

  typedef struct packed {
    logic       accept;
    logic       start;
    logic       out_load;
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } sts_t;

  // keeps the low one to three bytes of a partial last word
  function automatic logic [DATA_W-1:0] tail_mask(input logic [1:0] nb);
    logic [DATA_W-1:0] m;
    begin
      case (nb)
        2'd1:    m = 32'h0000_00ff;
        2'd2:    m = 32'h0000_ffff;
        2'd3:    m = 32'h00ff_ffff;
        default: m = 32'h0000_0000;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/murmur2_hash_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------------------
// item in   | item_valid/item_ready | data_word valid_bytes first_word last_word message_length
// hash out  | hash_valid/hash_ready | hash_value
// config    | psel/penable/pready   | paddr pwrite pwdata prdata (seed at 0x0)
//
// one item is in flight at a time; all multiplies go through one 32x32 unit
// full word: accept, two key multiplies, hash multiply; last word with four bytes: those steps
// then final mix and output load; with one to three: accept, tail multiply, final mix, output
// load; with none: accept, final mix, output load; each plus any wait for the output register
// to drain; a word outside an open message is accepted and dropped
// rst is synchronous; clears the sequencer, message flag, output valid, seed

module murmur2_hash_engine_core
  import mm2hash_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // item channel
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic [DATA_W-1:0] data_word,
  input  wire logic [VB_W-1:0]   valid_bytes,
  input  wire logic              first_word,
  input  wire logic              last_word,
  input  wire logic [LEN_W-1:0]  message_length,
  // hash channel
  output logic                   hash_valid,
  input  wire logic              hash_ready,
  output logic [DATA_W-1:0]      hash_value,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  `include "murmur2_hash_engine_core_macros.svh"

  logic [DATA_W-1:0] seed;
  logic              seed_sel;
  cmd_t              cmd;
  sts_t              sts;

  // register decode: index sits above the byte offset
  assign pready   = 1'b1;
  assign seed_sel = (paddr[ADDR_W-1] == REG_SEED);
  assign prdata   = seed_sel ? seed : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (psel && penable && pwrite && pready && seed_sel) begin
      seed <= pwdata;
    end
  end

  // sequencer: decides the multiply for each cycle
  mm2hash_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .valid_bytes (valid_bytes),
    .first_word  (first_word),
    .last_word   (last_word),
    .sts         (sts),
    .cmd         (cmd)
  );

  // key/hash registers, shared multiplier and output register
  mm2hash_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .seed           (seed),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .message_length (message_length),
    .hash_value     (hash_value),
    .hash_valid     (hash_valid),
    .hash_ready     (hash_ready)
  );

  // a result is only written into a free or draining output slot
  `MM2_ASSERT_NOW(a_load_free, cmd.out_load, sts.slot_free, "hash load into full slot")
  // no item is taken while a result is being handed over
  `MM2_ASSERT_NOW(a_load_busy, cmd.out_load, !item_ready, "item taken during hash load")
  // a loaded result shows up as valid the next cycle
  `MM2_ASSERT_NEXT(a_load_vld, cmd.out_load, hash_valid, "loaded hash not presented")

endmodule

`default_nettype wire

// ----- hw/rtl/mm2hash_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm2hash_dp
  import mm2hash_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic [DATA_W-1:0] seed,
  input  wire logic [DATA_W-1:0] data_word,
  input  wire logic [VB_W-1:0]   valid_bytes,
  input  wire logic [LEN_W-1:0]  message_length,
  output logic [DATA_W-1:0]      hash_value,
  output logic                   hash_valid,
  input  wire logic              hash_ready
);

  logic [DATA_W-1:0] word_q;
  logic [1:0]        nb_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] hash_q;
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] product;

  // one shared multiplier, operand picked per step
  always_comb begin
    case (cmd.op)
      OP_KEY1: mul_a = word_q;
      OP_KEY2: mul_a = key_q ^ (key_q >> 24);
      OP_HASH: mul_a = hash_q;
      OP_TAIL: mul_a = hash_q ^ (word_q & tail_mask(nb_q));
      OP_FIN:  mul_a = hash_q ^ (hash_q >> 13);
      default: mul_a = '0;
    endcase
  end

  assign product = mul_a * MUL_CONST;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_q <= data_word;
      nb_q   <= valid_bytes[1:0];
    end
    if (cmd.accept && cmd.start) begin
      hash_q <= seed ^ {1'b0, message_length};
    end
    case (cmd.op)
      OP_KEY1, OP_KEY2: key_q  <= product;
      OP_HASH:          hash_q <= product ^ key_q;
      OP_TAIL, OP_FIN:  hash_q <= product;
      default:          ;
    endcase
    if (cmd.out_load) begin
      hash_value <= hash_q ^ (hash_q >> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (cmd.out_load) begin
      hash_valid <= 1'b1;
    end else if (hash_ready) begin
      hash_valid <= 1'b0;
    end
  end

  assign sts.slot_free = !hash_valid || hash_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/mm2hash_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm2hash_ctrl
  import mm2hash_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire logic [VB_W-1:0] valid_bytes,
  input  wire logic            first_word,
  input  wire logic            last_word,
  input  wire sts_t            sts,
  output cmd_t                 cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY1 = 3'd1;
  localparam logic [2:0] S_KEY2 = 3'd2;
  localparam logic [2:0] S_HASH = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_msg;
  logic       in_msg_next;
  logic       last_q;
  logic       last_q_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    in_msg_next  = in_msg;
    last_q_next  = last_q;
    cmd.accept   = 1'b0;
    cmd.start    = 1'b0;
    cmd.out_load = 1'b0;
    cmd.op       = OP_NONE;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          // words outside an open message are dropped
          if (first_word || in_msg) begin
            cmd.start   = first_word;
            in_msg_next = 1'b1;
            last_q_next = last_word;
            if (!last_word || valid_bytes[2]) begin
              state_next = S_KEY1;
            end else if (valid_bytes[1:0] != 2'd0) begin
              state_next = S_TAIL;
            end else begin
              state_next = S_FIN;
            end
          end
        end
      end
      S_KEY1: begin
        cmd.op     = OP_KEY1;
        state_next = S_KEY2;
      end
      S_KEY2: begin
        cmd.op     = OP_KEY2;
        state_next = S_HASH;
      end
      S_HASH: begin
        cmd.op     = OP_HASH;
        state_next = last_q ? S_FIN : S_IDLE;
      end
      S_TAIL: begin
        cmd.op     = OP_TAIL;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op      = OP_FIN;
        in_msg_next = 1'b0;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_msg <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      in_msg <= in_msg_next;
      last_q <= last_q_next;
    end
  end

endmodule

`default_nettype wire
